// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising clock edge outside reset.
`define BHMT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bhmt assertion failed");

// Check that cond never holds outside reset.
`define BHMT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bhmt forbidden condition seen");

`else

`define BHMT_ASSERT(label, clk, rst_n, prop)
`define BHMT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: design/bhmt_pkg.sv
// ----------------------------------------------------------------------------
// bhmt_pkg
// Types and constants of the bucketed hash match table.
// ----------------------------------------------------------------------------
`default_nettype none

package bhmt_pkg;

  localparam int NUM_BUCKETS_DEF      = 257;
  localparam int SLOTS_PER_BUCKET_DEF = 4;

  localparam int CLOCK_ID_W = 64;
  localparam int KEY_REST_W = 48;
  localparam int STAMP_W    = 32;

  // Bucket hash: 32-bit word reduced mod bucket count, a few bits per cycle
  localparam int HASH_WORD_W        = 32;
  localparam int HASH_BITS_PER_STEP = 4;
  localparam int HASH_STEPS         = HASH_WORD_W / HASH_BITS_PER_STEP;
  localparam int STEP_W             = $clog2(HASH_STEPS);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_MEMBER = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [CLOCK_ID_W-1:0]   clock_identity;
    logic [15:0]             port_number;
    logic [7:0]              in_port;
    logic [7:0]              out_port;
    logic [15:0]             sequence_id;
    logic [STAMP_W-1:0]      stamp_in;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic [STAMP_W-1:0]      stamp_out;
    logic                    bucket_flushed;
  } out_word_t;

  typedef struct packed {
    logic                    valid;
    logic [CLOCK_ID_W-1:0]   clock_id;
    logic [KEY_REST_W-1:0]   key_rest;
    logic [STAMP_W-1:0]      stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_BASE,
    ST_READ,
    ST_CHECK,
    ST_ACT,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// File: design/bhmt_ram.sv
// ----------------------------------------------------------------------------
// bhmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bhmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/bucketed_hash_match_table_unit.sv
// ----------------------------------------------------------------------------
// bucketed_hash_match_table_unit
// Set-associative match table for timing message keys: insert, find,
// delete and member queries against one hashed bucket of slots.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid / in_ready    | in_data  (in_word_t)
//   out     | output    | out_valid / out_ready  | out_data (out_word_t)
//
// Flow: one word at a time, through hash, bucket base, a read and a check per
//   slot on the single read port, then act; a full-bucket flush adds a write
//   per slot after act.
// Reset: sweep the table one entry a cycle, all NUM_BUCKETS * SLOTS_PER_BUCKET
//   entries (1028 at the defaults); in_ready stays low until the sweep ends.
// Stalls: a waiting result still lets the next word in; only its result holds
//   in the act state (or on the last flush slot) until the output frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bucketed_hash_match_table_unit #(
  parameter int NUM_BUCKETS      = bhmt_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = bhmt_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bhmt_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bhmt_pkg::out_word_t       out_data
);

  import bhmt_pkg::*;

  localparam int DEPTH  = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  localparam logic [BKT_W:0]    NB_VAL     = NUM_BUCKETS[BKT_W:0];
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS_PER_BUCKET - 1);
  localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(DEPTH - 1);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(HASH_STEPS - 1);

  // Control state
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request registers
  opcode_t               opcode_r, opcode_nxt;
  logic [CLOCK_ID_W-1:0] cid_r, cid_nxt;
  logic [KEY_REST_W-1:0] rest_r, rest_nxt;
  logic [STAMP_W-1:0]    stamp_r, stamp_nxt;

  // Hash unit and bucket addressing
  logic [HASH_WORD_W-1:0] hash_word_r, hash_word_nxt;
  logic [BKT_W-1:0]       rem_r, rem_nxt;
  logic [BKT_W-1:0]       rem_calc;
  logic [BKT_W:0]         trial;
  logic [ADDR_W-1:0]      base_r, base_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SLOT_W-1:0]      slot_sel;
  logic [ADDR_W-1:0]      addr_sum;

  // Probe results
  logic                match_found_r, match_found_nxt;
  logic [SLOT_W-1:0]   match_slot_r, match_slot_nxt;
  logic [STAMP_W-1:0]  match_stamp_r, match_stamp_nxt;
  logic                free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]   free_slot_r, free_slot_nxt;

  // Output register
  out_word_t           out_data_r, out_data_nxt;

  // Table port
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  entry_t              ram_wentry;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;

  logic                out_free;
  logic                act_flush;

  assign rd_entry  = entry_t'(ram_rdata);
  assign out_free  = !out_valid_r || out_ready;
  // Insert that neither matched nor found a free slot clears the bucket
  assign act_flush = (opcode_r == OP_INSERT) && !match_found_r && !free_found_r;

  // Shared address adder: bucket base plus the slot in use
  assign addr_sum  = base_r + ADDR_W'(slot_sel);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_idx_r : addr_sum;

  // Mod unit: fold HASH_BITS_PER_STEP bits of the word into the remainder each step
  always_comb begin
    rem_calc = rem_r;
    trial    = '0;
    for (int i = 0; i < HASH_BITS_PER_STEP; i++) begin
      trial = {rem_calc, hash_word_r[HASH_WORD_W-1-i]};
      if (trial >= NB_VAL) begin
        trial = trial - NB_VAL;
      end
      rem_calc = trial[BKT_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == LAST_ENTRY) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = (slot_r == LAST_SLOT) ? ST_ACT : ST_READ;
      end
      ST_ACT: begin
        if (act_flush) begin
          state_nxt = ST_FLUSH;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (slot_r == LAST_SLOT && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    out_valid       = out_valid_r;
    out_data        = out_data_r;

    clr_idx_nxt     = clr_idx_r;
    step_nxt        = step_r;
    opcode_nxt      = opcode_r;
    cid_nxt         = cid_r;
    rest_nxt        = rest_r;
    stamp_nxt       = stamp_r;
    hash_word_nxt   = hash_word_r;
    rem_nxt         = rem_r;
    base_nxt        = base_r;
    slot_nxt        = slot_r;
    match_found_nxt = match_found_r;
    match_slot_nxt  = match_slot_r;
    match_stamp_nxt = match_stamp_r;
    free_found_nxt  = free_found_r;
    free_slot_nxt   = free_slot_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    slot_sel        = slot_r;
    ram_we          = 1'b0;
    ram_wentry      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid) begin
          opcode_nxt    = in_data.opcode;
          cid_nxt       = in_data.clock_identity;
          rest_nxt      = {in_data.port_number, in_data.in_port,
                           in_data.out_port, in_data.sequence_id};
          stamp_nxt     = in_data.stamp_in;
          hash_word_nxt = {in_data.clock_identity[3:0], in_data.port_number[3:0],
                           in_data.in_port[3:0], in_data.out_port[3:0],
                           in_data.sequence_id};
          rem_nxt       = '0;
          step_nxt      = '0;
        end
      end
      ST_HASH: begin
        rem_nxt       = rem_calc;
        hash_word_nxt = hash_word_r << HASH_BITS_PER_STEP;
        step_nxt      = step_r + 1'b1;
      end
      ST_BASE: begin
        base_nxt        = ADDR_W'(rem_r) * ADDR_W'(SLOTS_PER_BUCKET);
        slot_nxt        = '0;
        match_found_nxt = 1'b0;
        free_found_nxt  = 1'b0;
        match_slot_nxt  = '0;
        free_slot_nxt   = '0;
        match_stamp_nxt = '0;
      end
      ST_READ: begin
        // read address is addr_sum with slot_r; data lands next cycle
      end
      ST_CHECK: begin
        if (rd_entry.valid) begin
          if (!match_found_r && rd_entry.clock_id == cid_r
              && rd_entry.key_rest == rest_r) begin
            match_found_nxt = 1'b1;
            match_slot_nxt  = slot_r;
            match_stamp_nxt = rd_entry.stamp;
          end
        end else if (!free_found_r) begin
          free_found_nxt = 1'b1;
          free_slot_nxt  = slot_r;
        end
        slot_nxt = slot_r + 1'b1;
      end
      ST_ACT: begin
        if (act_flush) begin
          slot_nxt = '0;
        end else if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.hit            = match_found_r;
          out_data_nxt.bucket_flushed = 1'b0;
          out_data_nxt.stamp_out      = (opcode_r == OP_FIND && match_found_r)
                                        ? match_stamp_r : '0;
          unique case (opcode_r)
            OP_INSERT: begin
              // store into the first free slot unless the key is present
              slot_sel            = free_slot_r;
              ram_we              = !match_found_r;
              ram_wentry.valid    = 1'b1;
              ram_wentry.clock_id = cid_r;
              ram_wentry.key_rest = rest_r;
              ram_wentry.stamp    = stamp_r;
            end
            OP_FIND, OP_DELETE: begin
              // drop the matching entry
              slot_sel = match_slot_r;
              ram_we   = match_found_r;
            end
            OP_MEMBER: begin
            end
          endcase
        end
      end
      ST_FLUSH: begin
        // invalidate one slot per cycle; hold on the last slot until output frees
        ram_we = 1'b1;
        if (slot_r != LAST_SLOT) begin
          slot_nxt = slot_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.hit            = 1'b0;
          out_data_nxt.stamp_out      = '0;
          out_data_nxt.bucket_flushed = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opcode_r      <= opcode_nxt;
    cid_r         <= cid_nxt;
    rest_r        <= rest_nxt;
    stamp_r       <= stamp_nxt;
    hash_word_r   <= hash_word_nxt;
    rem_r         <= rem_nxt;
    base_r        <= base_nxt;
    slot_r        <= slot_nxt;
    match_found_r <= match_found_nxt;
    match_slot_r  <= match_slot_nxt;
    match_stamp_r <= match_stamp_nxt;
    free_found_r  <= free_found_nxt;
    free_slot_r   <= free_slot_nxt;
    out_data_r    <= out_data_nxt;
  end

  bhmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wentry),
    .raddr(addr_sum),
    .rdata(ram_rdata)
  );

  `BHMT_ASSERT_NEVER(a_no_write_idle, clk, rst_n, ram_we && state_r == ST_IDLE)
  `BHMT_ASSERT(a_result_from_act, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_ACT || state_r == ST_FLUSH))
  `BHMT_ASSERT_NEVER(a_flush_no_hit, clk, rst_n, out_valid_r && out_data_r.hit && out_data_r.bucket_flushed)
  `BHMT_ASSERT(a_stamp_needs_hit, clk, rst_n, (out_valid_r && out_data_r.stamp_out != '0) |-> out_data_r.hit)
  `BHMT_ASSERT(a_no_accept_in_sweep, clk, rst_n, (state_r == ST_CLEAR) |-> !in_ready)

endmodule

`default_nettype wire

// File: test/bucketed_hash_match_table_unit_test.sv
// ----------------------------------------------------------------------------
// bucketed_hash_match_table_unit_test
// Self-checking bench for the bucketed hash match table. A shadow copy of
// the table predicts hit, stamp and flush for every accepted request word.
// Stimulus starts with a directed pass over misses, duplicates, holes, flushes
// and extreme keys. It then hammers a few crowded buckets with random keys,
// opcodes and stamps, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_hash_match_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bhmt_pkg::*;

  localparam int NB          = NUM_BUCKETS_DEF;
  localparam int SLOTS       = SLOTS_PER_BUCKET_DEF;
  localparam int TABLE_DEPTH = NB * SLOTS;
  localparam int FAMILIES    = 6;   // crowded buckets for the random part
  localparam int VARIANTS    = 6;   // keys per crowded bucket, more than SLOTS
  localparam int RANDOM_WORDS = 375;
  localparam int DRAIN_CYCLES = 40; // covers the longest flush plus idle return

  // Receiver stall patterns, each held for a random stretch of cycles.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_RHYTHM
  } rx_mode_t;

  // --------------------------------------------------------------------------
  // Shadow of the match table: holds every slot and the queue of result
  // words that the block still owes.
  // --------------------------------------------------------------------------
  class hash_table_shadow;
    bit              slot_valid    [TABLE_DEPTH];
    logic [63:0]     slot_clock_id [TABLE_DEPTH];
    logic [47:0]     slot_key_rest [TABLE_DEPTH];
    logic [31:0]     slot_stamp    [TABLE_DEPTH];
    out_word_t       owed_words[$];
    int unsigned     mismatches;
    int unsigned     requests_seen;
    int unsigned     hits_seen;
    int unsigned     flushes_seen;
    int unsigned     results_checked;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      mismatches      = 0;
      requests_seen   = 0;
      hits_seen       = 0;
      flushes_seen    = 0;
      results_checked = 0;
    endfunction

    // Apply one accepted request to the shadow and queue the word it owes.
    function void note_request(in_word_t w);
      logic [31:0] hash_word;
      logic [47:0] key_rest;
      int unsigned base;
      int          match_slot;
      int          free_slot;
      out_word_t   owed;
      key_rest   = {w.port_number, w.in_port, w.out_port, w.sequence_id};
      hash_word  = {w.clock_identity[3:0], w.port_number[3:0], w.in_port[3:0],
                    w.out_port[3:0], w.sequence_id};
      base       = (hash_word % NB) * SLOTS;
      match_slot = -1;
      free_slot  = -1;
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_valid[base + s]) begin
          if (match_slot < 0 && slot_clock_id[base + s] == w.clock_identity &&
              slot_key_rest[base + s] == key_rest) begin
            match_slot = s;
          end
        end else if (free_slot < 0) begin
          free_slot = s;
        end
      end
      owed     = '0;
      owed.hit = (match_slot >= 0);
      case (w.opcode)
        OP_INSERT: begin
          if (match_slot < 0) begin
            if (free_slot >= 0) begin
              slot_valid[base + free_slot]    = 1'b1;
              slot_clock_id[base + free_slot] = w.clock_identity;
              slot_key_rest[base + free_slot] = key_rest;
              slot_stamp[base + free_slot]    = w.stamp_in;
            end else begin
              for (int s = 0; s < SLOTS; s++) slot_valid[base + s] = 1'b0;
              owed.bucket_flushed = 1'b1;
            end
          end
        end
        OP_FIND: begin
          if (match_slot >= 0) begin
            owed.stamp_out                = slot_stamp[base + match_slot];
            slot_valid[base + match_slot] = 1'b0;
          end
        end
        OP_DELETE: begin
          if (match_slot >= 0) slot_valid[base + match_slot] = 1'b0;
        end
        default: begin
        end
      endcase
      requests_seen++;
      if (owed.hit) hits_seen++;
      if (owed.bucket_flushed) flushes_seen++;
      owed_words.push_back(owed);
    endfunction

    // Compare one delivered result word with the oldest owed word.
    function void check_result(out_word_t got);
      out_word_t owed;
      if (owed_words.size() == 0) begin
        $error("result word with nothing owed: hit=%0d stamp_out=%0h flushed=%0d",
               got.hit, got.stamp_out, got.bucket_flushed);
        mismatches++;
        return;
      end
      owed = owed_words.pop_front();
      results_checked++;
      if (got.hit !== owed.hit) begin
        $error("hit: expected %0d, got %0d", owed.hit, got.hit);
        mismatches++;
      end
      if (got.stamp_out !== owed.stamp_out) begin
        $error("stamp_out: expected %0h, got %0h", owed.stamp_out, got.stamp_out);
        mismatches++;
      end
      if (got.bucket_flushed !== owed.bucket_flushed) begin
        $error("bucket_flushed: expected %0d, got %0d",
               owed.bucket_flushed, got.bucket_flushed);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  bucketed_hash_match_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hash_table_shadow shadow = new();

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: well past the slowest legal run (sweep after reset plus a few
  // hundred words, each at its flush latency behind the longest stalls).
  initial begin
    #5_000_000;
    $display("bucketed_hash_match_table_unit_test NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: check every delivered word, then pick the next ready level.
  // Each stall pattern holds for a random stretch so gaps land on every
  // phase of the block's work, and open stretches stay stall-free.
  // --------------------------------------------------------------------------
  rx_mode_t    rx_mode  = RX_OPEN;
  int unsigned rx_left  = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_result(out_data);
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ((rx_left % 8) < 5);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Present one request word and hold it until the block takes it.
  task automatic push_request(input in_word_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(w);
  endtask

  // Send a word inside the burst pattern: after each burst, drop valid for a
  // random gap, or run straight into the next burst about a third of the time.
  task automatic offer(input in_word_t w);
    int unsigned gap;
    push_request(w);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic in_word_t make_request(opcode_t opc, logic [63:0] cid,
                                            logic [15:0] pn, logic [7:0] ip,
                                            logic [7:0] ep, logic [15:0] seq,
                                            logic [31:0] ns);
    in_word_t w;
    w.opcode         = opc;
    w.clock_identity = cid;
    w.port_number    = pn;
    w.in_port        = ip;
    w.out_port       = ep;
    w.sequence_id    = seq;
    w.stamp_in       = ns;
    return w;
  endfunction

  // Keys of one family share their hashed nibbles and sequence id (or the
  // sequence id plus the bucket count), so they all land in one bucket.
  in_word_t family_key [FAMILIES][VARIANTS];

  // Mostly crowded-bucket traffic with random stamps; some pure noise.
  function automatic in_word_t random_request();
    in_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      w.opcode         = opcode_t'($urandom_range(0, 3));
      w.clock_identity = {$urandom, $urandom};
      w.port_number    = 16'($urandom);
      w.in_port        = 8'($urandom);
      w.out_port       = 8'($urandom);
      w.sequence_id    = 16'($urandom);
    end else begin
      w    = family_key[$urandom_range(0, FAMILIES - 1)][$urandom_range(0, VARIANTS - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 40)      w.opcode = OP_INSERT;
      else if (pick < 65) w.opcode = OP_FIND;
      else if (pick < 80) w.opcode = OP_DELETE;
      else                w.opcode = OP_MEMBER;
    end
    w.stamp_in = $urandom;
    return w;
  endfunction

  initial begin
    logic [63:0] ones64;
    logic [3:0]  cid_nib;
    logic [3:0]  pn_nib;
    logic [3:0]  ip_nib;
    logic [3:0]  ep_nib;
    logic [15:0] seq_base;
    in_word_t    k;

    ones64 = '1;

    // Build the crowded-bucket key families.
    for (int g = 0; g < FAMILIES; g++) begin
      cid_nib  = 4'($urandom);
      pn_nib   = 4'($urandom);
      ip_nib   = 4'($urandom);
      ep_nib   = 4'($urandom);
      seq_base = 16'($urandom);
      for (int v = 0; v < VARIANTS; v++) begin
        k                     = '0;
        k.clock_identity      = {$urandom, $urandom};
        k.clock_identity[3:0] = cid_nib;
        k.port_number         = 16'($urandom);
        k.port_number[3:0]    = pn_nib;
        k.in_port             = 8'($urandom);
        k.in_port[3:0]        = ip_nib;
        k.out_port            = 8'($urandom);
        k.out_port[3:0]       = ep_nib;
        k.sequence_id         = seq_base;
        // Shift some variants by the bucket count: same bucket, new key.
        if (v % 2 == 1 && seq_base <= 16'hFEFE) k.sequence_id = seq_base + 16'(NB);
        family_key[g][v] = k;
      end
    end

    // Hold reset, then release it; the block then sweeps its table with
    // in_ready low, which push_request simply waits out.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: misses on an empty table with the all-ones key.
    offer(make_request(OP_MEMBER, ones64, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, '1));
    offer(make_request(OP_FIND,   ones64, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, '1));
    offer(make_request(OP_DELETE, ones64, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, '1));
    // Insert, duplicate insert (stamp must not change), member, find, find again.
    offer(make_request(OP_INSERT, ones64, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, '1));
    offer(make_request(OP_INSERT, ones64, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, '0));
    offer(make_request(OP_MEMBER, ones64, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, '0));
    offer(make_request(OP_FIND,   ones64, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, '0));
    offer(make_request(OP_FIND,   ones64, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, '0));
    // All-zero key: insert, member, delete, member.
    offer(make_request(OP_INSERT, '0, '0, '0, '0, '0, '0));
    offer(make_request(OP_MEMBER, '0, '0, '0, '0, '0, '1));
    offer(make_request(OP_DELETE, '0, '0, '0, '0, '0, '1));
    offer(make_request(OP_MEMBER, '0, '0, '0, '0, '0, '1));
    // Fill one bucket, punch a hole, refill it, then overflow to force a flush.
    for (int j = 0; j < SLOTS; j++) begin
      offer(make_request(OP_INSERT, {60'(j), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234,
                         32'(100 + j)));
    end
    offer(make_request(OP_DELETE, {60'(1), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234, '0));
    offer(make_request(OP_INSERT, {60'(4), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234,
                       32'd104));
    offer(make_request(OP_FIND,   {60'(4), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234, '0));
    offer(make_request(OP_INSERT, {60'(4), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234,
                       32'd204));
    offer(make_request(OP_INSERT, {60'(5), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234,
                       32'd105));
    offer(make_request(OP_MEMBER, {60'(0), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234, '0));
    offer(make_request(OP_INSERT, {60'(0), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234,
                       32'hDEAD_BEEF));
    // Same bucket, different sequence id: must not match the stored key.
    offer(make_request(OP_MEMBER, {60'(0), 4'h5}, 16'h0A13, 8'h7A, 8'h3C,
                       16'h1234 + 16'(NB), '0));
    offer(make_request(OP_FIND,   {60'(0), 4'h5}, 16'h0A13, 8'h7A, 8'h3C, 16'h1234, '0));

    // Random traffic aimed at the crowded buckets.
    for (int n = 0; n < RANDOM_WORDS; n++) offer(random_request());

    // Drain: drop valid, wait for every owed word, then let the block settle.
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d hits, %0d bucket flushes, %0d results checked",
             shadow.requests_seen, shadow.hits_seen, shadow.flushes_seen,
             shadow.results_checked);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("bucketed_hash_match_table_unit_test OK");
    end else begin
      $display("bucketed_hash_match_table_unit_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+design
design/bhmt_pkg.sv
design/bhmt_ram.sv
design/bucketed_hash_match_table_unit.sv
test/bucketed_hash_match_table_unit_test.sv
